[rtl/core/gcdm_pkg.sv]
// Shared constants, types and helper functions of the grid cell dot matrix decoder.
package gcdm_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int GRID_SIZE  = 8;
  localparam int GRID_W     = $clog2(GRID_SIZE);

  localparam int DIM_W    = 12;
  localparam int THRESH_W = 8;
  localparam int PIX_W    = 8;

  localparam int WIDTH_W  = $clog2(MAX_WIDTH + 1);
  localparam int HEIGHT_W = $clog2(MAX_HEIGHT + 1);
  localparam int XPOS_W   = $clog2(MAX_WIDTH);
  localparam int YPOS_W   = $clog2(MAX_HEIGHT);
  localparam int XCELL_W  = (MAX_WIDTH / GRID_SIZE > 1) ? $clog2(MAX_WIDTH / GRID_SIZE) : 1;
  localparam int YCELL_W  = (MAX_HEIGHT / GRID_SIZE > 1) ? $clog2(MAX_HEIGHT / GRID_SIZE) : 1;

  localparam int RESET_WIDTH  = 64;
  localparam int RESET_HEIGHT = 64;
  localparam int RESET_THRESH = 185;

  // Grey conversion in 14-bit fixed point; the coefficients sum to one.
  localparam int COEF_B     = 1868;
  localparam int COEF_G     = 9617;
  localparam int COEF_R     = 4899;
  localparam int GREY_FRAC  = 14;
  localparam int GREY_ROUND = 1 << (GREY_FRAC - 1);
  localparam int GREY_SUM_W = PIX_W + GREY_FRAC;

  // A cell is set when white > black / 100, which equals 100 * white - black > 0.
  localparam int WHITE_WEIGHT = 100;
  localparam int CELL_PIX     = (MAX_WIDTH / GRID_SIZE) * (MAX_HEIGHT / GRID_SIZE);
  localparam int METRIC_W     = $clog2(CELL_PIX * WHITE_WEIGHT + 1) + 1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int NUM_REGS  = 3;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = $clog2(NUM_REGS * 4);
  localparam int REG_IDX_W = ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_ROI_WIDTH  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_ROI_HEIGHT = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD  = REG_IDX_W'(2);

  typedef struct packed {
    logic [WIDTH_W-1:0]  width;
    logic [HEIGHT_W-1:0] height;
    logic [THRESH_W-1:0] threshold;
    logic                restart;
  } gcdm_cfg_t;

  typedef struct packed {
    logic              counted;
    logic [GRID_W-1:0] col;
    logic [PIX_W-1:0]  grey;
    logic              row_end;
    logic [GRID_W-1:0] row;
  } gcdm_item_t;

  function automatic int clamp_dim(input logic [DIM_W-1:0] raw, input int hi);
    int v;
    v = int'(raw);
    if (v < GRID_SIZE) begin
      return GRID_SIZE;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

endpackage

[rtl/core/gcdm_regs.sv]
// Configuration register file behind the APB-style port.
module gcdm_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gcdm_pkg::ADDR_W-1:0]  paddr,
  input  logic [gcdm_pkg::DATA_W-1:0]  pwdata,
  output logic [gcdm_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output gcdm_pkg::gcdm_cfg_t          cfg
);

  logic [gcdm_pkg::DIM_W-1:0]    raw_width;
  logic [gcdm_pkg::DIM_W-1:0]    raw_height;
  logic [gcdm_pkg::THRESH_W-1:0] threshold;
  logic [gcdm_pkg::WIDTH_W-1:0]  width;
  logic [gcdm_pkg::HEIGHT_W-1:0] height;
  logic [gcdm_pkg::REG_IDX_W-1:0] idx;
  logic                          wr;

  assign pready = 1'b1;
  assign idx    = paddr[gcdm_pkg::ADDR_W-1:2];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_width  <= gcdm_pkg::DIM_W'(gcdm_pkg::RESET_WIDTH);
      raw_height <= gcdm_pkg::DIM_W'(gcdm_pkg::RESET_HEIGHT);
      threshold  <= gcdm_pkg::THRESH_W'(gcdm_pkg::RESET_THRESH);
      width      <= gcdm_pkg::WIDTH_W'(
                      gcdm_pkg::clamp_dim(gcdm_pkg::DIM_W'(gcdm_pkg::RESET_WIDTH),
                                          gcdm_pkg::MAX_WIDTH));
      height     <= gcdm_pkg::HEIGHT_W'(
                      gcdm_pkg::clamp_dim(gcdm_pkg::DIM_W'(gcdm_pkg::RESET_HEIGHT),
                                          gcdm_pkg::MAX_HEIGHT));
    end else if (wr) begin
      unique case (idx)
        gcdm_pkg::REG_ROI_WIDTH: begin
          raw_width <= pwdata[gcdm_pkg::DIM_W-1:0];
          width     <= gcdm_pkg::WIDTH_W'(
                         gcdm_pkg::clamp_dim(pwdata[gcdm_pkg::DIM_W-1:0],
                                             gcdm_pkg::MAX_WIDTH));
        end
        gcdm_pkg::REG_ROI_HEIGHT: begin
          raw_height <= pwdata[gcdm_pkg::DIM_W-1:0];
          height     <= gcdm_pkg::HEIGHT_W'(
                          gcdm_pkg::clamp_dim(pwdata[gcdm_pkg::DIM_W-1:0],
                                              gcdm_pkg::MAX_HEIGHT));
        end
        gcdm_pkg::REG_THRESHOLD: begin
          threshold <= pwdata[gcdm_pkg::THRESH_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      gcdm_pkg::REG_ROI_WIDTH:  prdata = gcdm_pkg::DATA_W'(raw_width);
      gcdm_pkg::REG_ROI_HEIGHT: prdata = gcdm_pkg::DATA_W'(raw_height);
      gcdm_pkg::REG_THRESHOLD:  prdata = gcdm_pkg::DATA_W'(threshold);
      default:                  prdata = '0;
    endcase
  end

  // A geometry write restarts the frame at the same edge.
  always_comb begin
    cfg.width     = width;
    cfg.height    = height;
    cfg.threshold = threshold;
    cfg.restart   = wr && (idx == gcdm_pkg::REG_ROI_WIDTH ||
                           idx == gcdm_pkg::REG_ROI_HEIGHT);
  end

endmodule

[rtl/core/gcdm_front.sv]
// Front end: accepts pixels, tracks the grid position and computes the grey level.
module gcdm_front (
  input  logic                        clk,
  input  logic                        rst,
  input  gcdm_pkg::gcdm_cfg_t         cfg,
  input  logic                        pix_valid,
  output logic                        pix_stall,
  input  logic [gcdm_pkg::PIX_W-1:0]  blue,
  input  logic [gcdm_pkg::PIX_W-1:0]  green,
  input  logic [gcdm_pkg::PIX_W-1:0]  red,
  input  logic                        q_full,
  output logic                        push,
  output gcdm_pkg::gcdm_item_t        item
);

  localparam int WX = gcdm_pkg::WIDTH_W + 1;
  localparam int WY = gcdm_pkg::HEIGHT_W + 1;

  logic [gcdm_pkg::XPOS_W-1:0]  x;
  logic [gcdm_pkg::YPOS_W-1:0]  y;
  logic [gcdm_pkg::XCELL_W-1:0] cx;
  logic [gcdm_pkg::YCELL_W-1:0] cy;
  logic [gcdm_pkg::GRID_W-1:0]  col;
  logic [gcdm_pkg::GRID_W-1:0]  row;

  logic [gcdm_pkg::WIDTH_W-1:0]  dc;
  logic [gcdm_pkg::HEIGHT_W-1:0] dr;
  logic [gcdm_pkg::XCELL_W-1:0]  dc_last;
  logic [gcdm_pkg::YCELL_W-1:0]  dr_last;
  logic [gcdm_pkg::GRID_W-1:0]   off_x;
  logic [gcdm_pkg::GRID_W-1:0]   off_y;
  logic [WX-1:0]                 end_x;
  logic [WY-1:0]                 end_y;
  logic                          x_started, y_started, x_in, y_in, x_last, y_last;
  logic [gcdm_pkg::GREY_SUM_W-1:0] grey_sum;

  assign dc      = cfg.width >> gcdm_pkg::GRID_W;
  assign dr      = cfg.height >> gcdm_pkg::GRID_W;
  assign dc_last = gcdm_pkg::XCELL_W'(dc - gcdm_pkg::WIDTH_W'(1));
  assign dr_last = gcdm_pkg::YCELL_W'(dr - gcdm_pkg::HEIGHT_W'(1));
  assign off_x   = cfg.width[gcdm_pkg::GRID_W-1:0] >> 1;
  assign off_y   = cfg.height[gcdm_pkg::GRID_W-1:0] >> 1;
  assign end_x   = WX'(dc << gcdm_pkg::GRID_W) + WX'(off_x);
  assign end_y   = WY'(dr << gcdm_pkg::GRID_W) + WY'(off_y);

  assign x_started = WX'(x) >= WX'(off_x);
  assign y_started = WY'(y) >= WY'(off_y);
  assign x_in      = x_started && (WX'(x) < end_x);
  assign y_in      = y_started && (WY'(y) < end_y);
  assign x_last    = (x == gcdm_pkg::XPOS_W'(cfg.width - gcdm_pkg::WIDTH_W'(1)));
  assign y_last    = (y == gcdm_pkg::YPOS_W'(cfg.height - gcdm_pkg::HEIGHT_W'(1)));

  assign grey_sum = gcdm_pkg::GREY_SUM_W'(gcdm_pkg::COEF_B * int'(blue) +
                                          gcdm_pkg::COEF_G * int'(green) +
                                          gcdm_pkg::COEF_R * int'(red) +
                                          gcdm_pkg::GREY_ROUND);

  assign pix_stall = q_full;
  assign push      = pix_valid && !q_full;

  always_comb begin
    item.counted = x_in && y_in;
    item.col     = col;
    item.grey    = grey_sum[gcdm_pkg::GREY_SUM_W-1 -: gcdm_pkg::PIX_W];
    item.row_end = x_last && y_in && (cy == dr_last);
    item.row     = row;
  end

  // Cell counters only advance once the left or top margin has been passed.
  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      x   <= '0;
      y   <= '0;
      cx  <= '0;
      cy  <= '0;
      col <= '0;
      row <= '0;
    end else if (push) begin
      if (x_last) begin
        x   <= '0;
        cx  <= '0;
        col <= '0;
        if (y_last) begin
          y   <= '0;
          cy  <= '0;
          row <= '0;
        end else begin
          y <= y + gcdm_pkg::YPOS_W'(1);
          if (y_started) begin
            if (cy == dr_last) begin
              cy  <= '0;
              row <= row + gcdm_pkg::GRID_W'(1);
            end else begin
              cy <= cy + gcdm_pkg::YCELL_W'(1);
            end
          end
        end
      end else begin
        x <= x + gcdm_pkg::XPOS_W'(1);
        if (x_started) begin
          if (cx == dc_last) begin
            cx  <= '0;
            col <= col + gcdm_pkg::GRID_W'(1);
          end else begin
            cx <= cx + gcdm_pkg::XCELL_W'(1);
          end
        end
      end
    end
  end

endmodule

[rtl/core/gcdm_fifo.sv]
// Short queue of classified pixels between the front and back ends.
module gcdm_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  gcdm_pkg::gcdm_item_t wr_item,
  input  logic                 pop,
  output gcdm_pkg::gcdm_item_t head,
  output logic                 full,
  output logic                 empty
);

  gcdm_pkg::gcdm_item_t          mem [gcdm_pkg::FIFO_DEPTH];
  logic [gcdm_pkg::FIFO_AW-1:0]  wr_ptr;
  logic [gcdm_pkg::FIFO_AW-1:0]  rd_ptr;
  logic [gcdm_pkg::FIFO_AW:0]    count;

  assign full  = (count == (gcdm_pkg::FIFO_AW + 1)'(gcdm_pkg::FIFO_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + gcdm_pkg::FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + gcdm_pkg::FIFO_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (gcdm_pkg::FIFO_AW + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (gcdm_pkg::FIFO_AW + 1)'(1);
      end
    end
  end

endmodule

[rtl/core/gcdm_back.sv]
// Back end: per-cell white/black balance, row byte assembly and output register.
module gcdm_back (
  input  logic                          clk,
  input  logic                          rst,
  input  gcdm_pkg::gcdm_cfg_t           cfg,
  input  logic                          q_empty,
  input  gcdm_pkg::gcdm_item_t          head,
  output logic                          pop,
  output logic                          row_valid,
  input  logic                          row_stall,
  output logic [gcdm_pkg::GRID_SIZE-1:0] row_byte,
  output logic [gcdm_pkg::GRID_W-1:0]   row_index,
  output logic                          last_row
);

  // Each cell keeps 100 * white - black; its bit is set when that is positive.
  logic signed [gcdm_pkg::METRIC_W-1:0] metric      [gcdm_pkg::GRID_SIZE];
  logic signed [gcdm_pkg::METRIC_W-1:0] metric_next [gcdm_pkg::GRID_SIZE];
  logic signed [gcdm_pkg::METRIC_W-1:0] delta;
  logic [gcdm_pkg::GRID_SIZE-1:0]       bits;
  logic                                 white;

  assign white = head.grey > cfg.threshold;
  assign pop   = !q_empty && (!head.row_end || !row_valid || !row_stall);

  always_comb begin
    delta = white ? gcdm_pkg::METRIC_W'(gcdm_pkg::WHITE_WEIGHT) : '1;
    for (int j = 0; j < gcdm_pkg::GRID_SIZE; j++) begin
      if (head.counted && head.col == gcdm_pkg::GRID_W'(j)) begin
        metric_next[j] = metric[j] + delta;
      end else begin
        metric_next[j] = metric[j];
      end
      bits[gcdm_pkg::GRID_SIZE-1-j] = !metric_next[j][gcdm_pkg::METRIC_W-1] &&
                                      (metric_next[j] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      for (int j = 0; j < gcdm_pkg::GRID_SIZE; j++) begin
        metric[j] <= '0;
      end
    end else if (pop) begin
      for (int j = 0; j < gcdm_pkg::GRID_SIZE; j++) begin
        metric[j] <= head.row_end ? '0 : metric_next[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= 1'b0;
    end else if (pop && head.row_end) begin
      row_valid <= 1'b1;
    end else if (!row_stall) begin
      row_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.row_end) begin
      row_byte  <= bits;
      row_index <= head.row;
      last_row  <= (head.row == gcdm_pkg::GRID_W'(gcdm_pkg::GRID_SIZE - 1));
    end
  end

endmodule

[rtl/core/grid_cell_dot_matrix_decoder_unit.sv]
// Top level of the grid cell dot matrix decoder.
//
// Pixels of the region of interest enter in raster order on the pixel channel
// (pix_valid, pix_stall, blue, green, red), one transfer per pixel. Each pixel
// is turned into grey, compared with the threshold and counted into one of
// the eight cells of the current grid row; margin pixels are taken and dropped.
// After the last pixel of a grid row the block offers one byte on the row
// channel (row_valid, row_stall, row_byte, row_index, last_row), column zero
// in bit seven; last_row marks the eighth byte of a frame.
// Throughput is one pixel per cycle while pix_stall is low. The pixel that
// closes a grid row is written into the four-entry queue; once the back end
// takes it from the queue, it passes through the cell update into the output
// register, which then holds the valid row byte.
// While row_stall holds, the byte waits in the output register and the queue
// fills behind the next row-closing pixel; pix_stall rises only when it is full.
// Reset restores the register defaults (64 by 64 region, threshold 185) and
// starts a fresh frame, as does a roi_width or roi_height write. Registers are
// to be written through the APB-style port while idle; the block does not enforce this.
module grid_cell_dot_matrix_decoder_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gcdm_pkg::ADDR_W-1:0]    paddr,
  input  logic [gcdm_pkg::DATA_W-1:0]    pwdata,
  output logic [gcdm_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  input  logic                           pix_valid,
  output logic                           pix_stall,
  input  logic [gcdm_pkg::PIX_W-1:0]     blue,
  input  logic [gcdm_pkg::PIX_W-1:0]     green,
  input  logic [gcdm_pkg::PIX_W-1:0]     red,
  output logic                           row_valid,
  input  logic                           row_stall,
  output logic [gcdm_pkg::GRID_SIZE-1:0] row_byte,
  output logic [gcdm_pkg::GRID_W-1:0]    row_index,
  output logic                           last_row
);

  gcdm_pkg::gcdm_cfg_t  cfg;
  gcdm_pkg::gcdm_item_t front_item;
  gcdm_pkg::gcdm_item_t head;
  logic                 push, pop, q_full, q_empty;

  gcdm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gcdm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .blue      (blue),
    .green     (green),
    .red       (red),
    .q_full    (q_full),
    .push      (push),
    .item      (front_item)
  );

  gcdm_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (front_item),
    .pop     (pop),
    .head    (head),
    .full    (q_full),
    .empty   (q_empty)
  );

  gcdm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .row_valid (row_valid),
    .row_stall (row_stall),
    .row_byte  (row_byte),
    .row_index (row_index),
    .last_row  (last_row)
  );

`ifndef SYNTHESIS
  // The queue is never written while full.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push)
    else $error("pixel queue written while full");

  // A row-closing item taken from the queue always shows up on the output.
  a_row_emitted: assert property (@(posedge clk) disable iff (rst)
    (pop && head.row_end) |=> row_valid)
    else $error("row byte lost after its closing pixel");

  // The end-of-frame flag and the grid row number agree.
  a_last_row: assert property (@(posedge clk) disable iff (rst)
    row_valid |-> (last_row == (row_index == gcdm_pkg::GRID_W'(gcdm_pkg::GRID_SIZE - 1))))
    else $error("last_row does not match row_index");
`endif

endmodule
